// File: rtl/core/pending_request_timeout_table_defines.svh
// ----------------------------------------------------------------------------
// Pending request timeout table: assertion macros
// Shared property forms for the checkers of the table.
// ----------------------------------------------------------------------------
`ifndef PENDING_REQUEST_TIMEOUT_TABLE_DEFINES_SVH
`define PENDING_REQUEST_TIMEOUT_TABLE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define PRTT_AST_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define PRTT_AST_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/prtt_pkg.sv
// ----------------------------------------------------------------------------
// Pending request timeout table: package
// Depth, field widths, operation and status codes, entry and control types.
// ----------------------------------------------------------------------------
package prtt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int TD_W        = $clog2(TABLE_DEPTH);

    localparam int KIND_W   = 2;
    localparam int ID_W     = 32;
    localparam int HDL_W    = 32;
    localparam int TICKS_W  = 16;
    localparam int STATUS_W = 3;

    typedef enum logic [KIND_W-1:0] {
        K_INSERT   = 2'd0,
        K_RESPONSE = 2'd1,
        K_TICK     = 2'd2,
        K_FLUSH    = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_REPLACED = 3'd1,
        ST_DROPPED  = 3'd2,
        ST_MATCHED  = 3'd3,
        ST_UNKNOWN  = 3'd4,
        ST_TIMEOUT  = 3'd5,
        ST_LOST     = 3'd6,
        ST_DONE     = 3'd7
    } t_status;

    typedef struct packed {
        logic               valid;
        logic [ID_W-1:0]    id;
        logic [HDL_W-1:0]   handle;
        logic [TICKS_W-1:0] count;
    } t_entry;

    typedef struct packed {
        logic            cmp;
        logic            shift;
        logic [ID_W-1:0] key;
        t_entry          wdata;
    } t_cell_ctl;

    typedef struct packed {
        t_status          status;
        logic [ID_W-1:0]  id;
        logic [HDL_W-1:0] handle;
        logic             last;
    } t_result;

endpackage

// File: rtl/core/prtt_if.sv
// ----------------------------------------------------------------------------
// Pending request timeout table: channel interfaces
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface prtt_req_if;
    import prtt_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [ID_W-1:0]    msg_id;
    logic [HDL_W-1:0]   callback_handle;
    logic [TICKS_W-1:0] timeout_ticks;

    modport source (output valid, kind, msg_id, callback_handle, timeout_ticks, input ready);
    modport sink   (input valid, kind, msg_id, callback_handle, timeout_ticks, output ready);
endinterface

interface prtt_rsp_if;
    import prtt_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     out_msg_id;
    logic [HDL_W-1:0]    out_handle;
    logic                last;

    modport source (output valid, status, out_msg_id, out_handle, last, input ready);
    modport sink   (input valid, status, out_msg_id, out_handle, last, output ready);
endinterface

// File: rtl/core/pending_request_timeout_table.sv
// ----------------------------------------------------------------------------
// Pending request timeout table
// Tracks outstanding requests by message id in a row of cells, with insert,
// response lookup, timeout aging and flush.
// ----------------------------------------------------------------------------
// Insert and response pass through the accept cycle, in which every cell
// compares its id with the key, and an act step that picks the matching or
// lowest free cell and writes the result register. Tick and flush pass
// through the accept cycle, one setup step, a walk of TABLE_DEPTH steps in
// which the row rotates once through its head cell, one entry per cycle in
// slot order, and a done step for the done result; each reported entry
// also waits for the result register to be free. One request is in work at a
// time; a new request is taken while the last result is still waiting on the
// result channel.
// ----------------------------------------------------------------------------
module pending_request_timeout_table (
    input  logic       i_clk,
    input  logic       i_rst_n,
    prtt_req_if.sink   i_req,
    prtt_rsp_if.source o_rsp
);
    import prtt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ACT  = 4'b0010,
        S_WALK = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    t_kind              r_kind;
    logic [ID_W-1:0]    r_key;
    logic [HDL_W-1:0]   r_hdl;
    logic [TICKS_W-1:0] r_ticks;
    logic [TD_W-1:0]    r_cnt, n_cnt;
    logic               r_ov, n_ov;
    t_result            r_out, n_out;

    t_entry             w_entry [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_hit, w_valid, w_free, w_free_oh, w_wr, w_clr;
    logic               w_any_hit, w_any_free, w_out_free, w_acc;
    logic               w_need_emit, w_step;
    logic [HDL_W-1:0]   w_hit_handle;
    t_entry             w_wrap;
    t_cell_ctl          w_ctl;

    assign w_acc        = i_req.valid && i_req.ready;
    assign i_req.ready  = (r_state == S_IDLE);
    assign w_out_free   = !r_ov || o_rsp.ready;

    always_comb begin
        w_hit_handle = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_valid[i]   = w_entry[i].valid;
            w_hit_handle = w_hit_handle | (w_hit[i] ? w_entry[i].handle : '0);
        end
    end

    assign w_any_hit  = |w_hit;
    assign w_free     = ~w_valid;
    assign w_any_free = |w_free;
    assign w_free_oh  = w_free & (~w_free + TABLE_DEPTH'(1));

    // head cell during a walk
    assign w_need_emit = w_entry[0].valid &&
                         ((r_kind == K_FLUSH) || (w_entry[0].count == '0));
    assign w_step      = !w_need_emit || w_out_free;

    always_comb begin
        w_wrap       = w_entry[0];
        w_wrap.valid = w_entry[0].valid && !w_need_emit;
        w_wrap.count = w_entry[0].count - TICKS_W'(1);
    end

    always_comb begin
        w_ctl.cmp   = w_acc;
        w_ctl.key   = i_req.msg_id;
        w_ctl.shift = (r_state == S_WALK) && w_step;
        w_ctl.wdata = '{valid: 1'b1, id: r_key, handle: r_hdl, count: r_ticks};
    end

    always_comb begin
        w_wr  = '0;
        w_clr = '0;
        if ((r_state == S_ACT) && w_out_free) begin
            if (r_kind == K_INSERT) begin
                w_wr = w_any_hit ? w_hit : w_free_oh;
            end else if (r_kind == K_RESPONSE) begin
                w_clr = w_hit;
            end
        end
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        t_entry w_next;
        if (g == TABLE_DEPTH - 1) begin : g_tail
            assign w_next = w_wrap;
        end else begin : g_mid
            assign w_next = w_entry[g+1];
        end
        prtt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_wr    (w_wr[g]),
            .i_clr   (w_clr[g]),
            .i_next  (w_next),
            .o_entry (w_entry[g]),
            .o_hit   (w_hit[g])
        );
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_out   = r_out;
        n_ov    = r_ov && !o_rsp.ready;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_state = S_ACT;
                end
            end
            S_ACT: begin
                if ((r_kind == K_TICK) || (r_kind == K_FLUSH)) begin
                    n_cnt   = '0;
                    n_state = S_WALK;
                end else if (w_out_free) begin
                    n_ov         = 1'b1;
                    n_out.id     = r_key;
                    n_out.handle = '0;
                    n_out.last   = 1'b1;
                    if (r_kind == K_INSERT) begin
                        n_out.status = w_any_hit  ? ST_REPLACED :
                                       w_any_free ? ST_INSERTED : ST_DROPPED;
                    end else begin
                        n_out.status = w_any_hit ? ST_MATCHED : ST_UNKNOWN;
                        n_out.handle = w_any_hit ? w_hit_handle : '0;
                    end
                    n_state = S_IDLE;
                end
            end
            S_WALK: begin
                if (w_step) begin
                    if (w_need_emit) begin
                        n_ov         = 1'b1;
                        n_out.status = (r_kind == K_FLUSH) ? ST_LOST : ST_TIMEOUT;
                        n_out.id     = w_entry[0].id;
                        n_out.handle = w_entry[0].handle;
                        n_out.last   = 1'b0;
                    end
                    n_cnt = r_cnt + TD_W'(1);
                    if (r_cnt == TD_W'(TABLE_DEPTH - 1)) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_ov    = 1'b1;
                    n_out   = '{status: ST_DONE, id: '0, handle: '0, last: 1'b1};
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_acc) begin
            r_kind  <= t_kind'(i_req.kind);
            r_key   <= i_req.msg_id;
            r_hdl   <= i_req.callback_handle;
            r_ticks <= i_req.timeout_ticks;
        end
    end

    assign o_rsp.valid      = r_ov;
    assign o_rsp.status     = r_out.status;
    assign o_rsp.out_msg_id = r_out.id;
    assign o_rsp.out_handle = r_out.handle;
    assign o_rsp.last       = r_out.last;

endmodule

// File: rtl/core/prtt_cell.sv
// ----------------------------------------------------------------------------
// Pending request timeout table: table cell
// Holds one entry, compares it against the lookup key and takes the entry
// of its neighbor when the row rotates.
// ----------------------------------------------------------------------------
module prtt_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  prtt_pkg::t_cell_ctl i_ctl,
    input  logic                i_wr,
    input  logic                i_clr,
    input  prtt_pkg::t_entry    i_next,
    output prtt_pkg::t_entry    o_entry,
    output logic                o_hit
);
    import prtt_pkg::*;

    logic               r_valid;
    logic               r_hit;
    logic [ID_W-1:0]    r_id;
    logic [HDL_W-1:0]   r_handle;
    logic [TICKS_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            if (i_ctl.shift) begin
                r_valid <= i_next.valid;
            end else if (i_wr) begin
                r_valid <= 1'b1;
            end else if (i_clr) begin
                r_valid <= 1'b0;
            end
            if (i_ctl.cmp) begin
                r_hit <= r_valid && (r_id == i_ctl.key);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_id     <= i_next.id;
            r_handle <= i_next.handle;
            r_count  <= i_next.count;
        end else if (i_wr) begin
            r_id     <= i_ctl.wdata.id;
            r_handle <= i_ctl.wdata.handle;
            r_count  <= i_ctl.wdata.count;
        end
    end

    assign o_entry = '{valid: r_valid, id: r_id, handle: r_handle, count: r_count};
    assign o_hit   = r_hit;

endmodule

// File: rtl/core/prtt_checker.sv
// ----------------------------------------------------------------------------
// Pending request timeout table: port checker
// Watches the request and result channels of the table.
// ----------------------------------------------------------------------------
`include "pending_request_timeout_table_defines.svh"

module prtt_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    prtt_req_if.sink   i_req,
    prtt_rsp_if.source o_rsp
);
    import prtt_pkg::*;

    logic                            w_req_acc;
    logic                            w_stall;
    logic                            w_end_st;
    logic                            w_zero_st;
    logic                            w_zero_ok;
    logic [STATUS_W+ID_W+HDL_W:0]    w_payload;

    assign w_req_acc = i_req.valid && i_req.ready;
    assign w_stall   = o_rsp.valid && !o_rsp.ready;
    assign w_payload = {o_rsp.status, o_rsp.out_msg_id, o_rsp.out_handle, o_rsp.last};
    assign w_end_st  = (o_rsp.status != ST_TIMEOUT) && (o_rsp.status != ST_LOST);
    assign w_zero_st = (o_rsp.status == ST_INSERTED) || (o_rsp.status == ST_REPLACED) ||
                       (o_rsp.status == ST_DROPPED) || (o_rsp.status == ST_UNKNOWN) ||
                       (o_rsp.status == ST_DONE);
    assign w_zero_ok = (o_rsp.out_handle == '0) &&
                       ((o_rsp.status != ST_DONE) || (o_rsp.out_msg_id == '0));

    `PRTT_AST_NEXT(a_rsp_hold, i_clk, i_rst_n, w_stall, o_rsp.valid && $stable(w_payload), "stalled result changed")
    `PRTT_AST_NOW(a_rst_empty, i_clk, i_rst_n, $past(!i_rst_n), !o_rsp.valid, "result valid after reset")
    `PRTT_AST_NOW(a_last_kind, i_clk, i_rst_n, o_rsp.valid, o_rsp.last == w_end_st, "last flag off")
    `PRTT_AST_NOW(a_zero_fields, i_clk, i_rst_n, o_rsp.valid && w_zero_st, w_zero_ok, "field not zero")
    `PRTT_AST_NEXT(a_req_busy, i_clk, i_rst_n, w_req_acc, !i_req.ready, "request taken while busy")

endmodule

bind pending_request_timeout_table prtt_port_checker u_prtt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_req   (i_req),
    .o_rsp   (o_rsp)
);
